@@ hw/rtl/integer_set_span_tracker_top_assert.svh @@
// Assertion macros for the integer set span tracker.
`ifndef INTEGER_SET_SPAN_TRACKER_TOP_ASSERT_SVH
`define INTEGER_SET_SPAN_TRACKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define ISST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("isst: assertion failed");
// Implication with the consequent in the next cycle.
`define ISST_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("isst: next-cycle assertion failed");
`else
`define ISST_ASSERT(lbl, prop)
`define ISST_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hw/rtl/isst_pkg.sv @@
// Shared widths, constants and types of the integer set span tracker.
`default_nettype none
package isst_pkg;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 11;
    localparam int COUNT_OUT_W     = 11;
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Control sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Status of the gap unit as seen by the sequencer.
    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] min_gap;
    } t_gap_stat;
endpackage
`default_nettype wire

@@ hw/rtl/isst_store.sv @@
// Value store: one write port and one read port with registered read data.
`default_nettype none
module isst_store #(
    parameter int MAX_ENTRIES = isst_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]        i_waddr,
    input  wire logic signed [isst_pkg::DATA_W-1:0]    i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]        i_raddr,
    output logic signed [isst_pkg::DATA_W-1:0]         o_rdata
);
    import isst_pkg::*;

    logic signed [DATA_W-1:0] r_mem [MAX_ENTRIES];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/isst_gap.sv @@
// Gap unit: compares the new value with each stored value and keeps the minimum gap.
`default_nettype none
module isst_gap (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_issue,
    input  wire logic signed [isst_pkg::DATA_W-1:0] i_rdata,
    input  wire logic signed [isst_pkg::DATA_W-1:0] i_value,
    output isst_pkg::t_gap_stat                     o_stat
);
    import isst_pkg::*;

    logic                     r_s1v;
    logic                     r_dv;
    logic                     r_gv;
    logic signed [DATA_W:0]   r_d;
    logic        [DATA_W-1:0] r_g;
    logic        [DATA_W-1:0] r_min_gap;
    logic        [DATA_W:0]   n_abs;

    // Stage valid flags; read data lines up with r_s1v.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_dv  <= 1'b0;
            r_gv  <= 1'b0;
        end else begin
            r_s1v <= i_issue;
            r_dv  <= r_s1v;
            r_gv  <= r_dv;
        end
    end

    // Signed difference at full width.
    always_ff @(posedge i_clk) begin
        if (r_s1v) begin
            r_d <= {i_value[DATA_W-1], i_value} - {i_rdata[DATA_W-1], i_rdata};
        end
    end

    // Magnitude of the difference always fits in the data width.
    always_comb begin
        n_abs = r_d[DATA_W] ? (~r_d + 1'b1) : r_d;
    end

    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            r_g <= n_abs[DATA_W-1:0];
        end
    end

    // Running minimum gap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= '1;
        end else if (r_gv && (r_g < r_min_gap)) begin
            r_min_gap <= r_g;
        end
    end

    assign o_stat.busy    = r_s1v | r_dv | r_gv;
    assign o_stat.min_gap = r_min_gap;
endmodule
`default_nettype wire

@@ hw/rtl/integer_set_span_tracker_top.sv @@
// Top level of the integer set span tracker: sequencer, state registers and result register.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | i_in_valid / o_in_stall    | i_new_value
//  out     | from block| o_out_valid / i_out_stall  | o_status, o_stored_count, o_too_few,
//          |           |                            | o_shortest_span, o_longest_span
//  cfg     | to block  | i_cfg_we                   | i_cfg_wdata (capacity)
//
// A stored value is scanned against every value already held (the scan is skipped when the
// set is empty): the single read port of the value store steps through them one per cycle.
// A full set rejects the value without a scan.
// Reset is synchronous; the value store needs no clearing, since only entries already
// written are ever read. A stalled result holds in the output register, and the next item
// is taken once it has been loaded there.
`default_nettype none
`include "integer_set_span_tracker_top_assert.svh"
module integer_set_span_tracker_top #(
    parameter int MAX_ENTRIES = isst_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [isst_pkg::CAP_W-1:0]            i_cfg_wdata,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [isst_pkg::DATA_W-1:0]    i_new_value,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic                                       o_status,
    output logic [isst_pkg::COUNT_OUT_W-1:0]           o_stored_count,
    output logic                                       o_too_few,
    output logic [isst_pkg::DATA_W-1:0]                o_shortest_span,
    output logic [isst_pkg::DATA_W-1:0]                o_longest_span
);
    import isst_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    t_state                   r_state;
    logic [CAP_W-1:0]         r_cap;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_idx;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_smallest;
    logic signed [DATA_W-1:0] r_largest;
    logic                     r_status;
    logic                     r_out_valid;
    logic                     r_o_status;
    logic [COUNT_OUT_W-1:0]   r_o_count;
    logic                     r_o_too_few;
    logic [DATA_W-1:0]        r_o_short;
    logic [DATA_W-1:0]        r_o_long;

    logic                     in_accept;
    logic                     full;
    logic                     issue;
    logic                     load;
    logic [CW-1:0]            count_m1;
    logic [AW-1:0]            last_idx;
    logic signed [DATA_W-1:0] rdata;
    logic [DATA_W:0]          span;
    t_gap_stat                gap_stat;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Handshake and control decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign full       = (XW'(r_count) >= XW'(r_cap)) || (r_count == CW'(MAX_ENTRIES));
    assign issue      = (r_state == S_SCAN);
    assign count_m1   = r_count - CW'(1);
    assign last_idx   = count_m1[AW-1:0];
    assign load       = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    isst_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_accept && !full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_new_value),
        .i_re    (issue),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    isst_gap u_gap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_rdata (rdata),
        .i_value (r_value),
        .o_stat  (gap_stat)
    );

    // Sequencer: accept, scan the stored values, drain the gap unit, present the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_smallest <= '0;
            r_largest  <= '0;
            r_idx      <= '0;
            r_status   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_idx    <= '0;
                        r_status <= full;
                        if (full) begin
                            r_state <= S_DONE;
                        end else if (r_count == '0) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == last_idx) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!gap_stat.busy) begin
                        if (r_count == '0) begin
                            r_smallest <= r_value;
                            r_largest  <= r_value;
                        end else begin
                            if (r_value < r_smallest) begin
                                r_smallest <= r_value;
                            end
                            if (r_value > r_largest) begin
                                r_largest <= r_value;
                            end
                        end
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Offered value, held through the scan.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_value <= i_new_value;
        end
    end

    // Longest span at full width, then truncated.
    assign span = {r_largest[DATA_W-1], r_largest} - {r_smallest[DATA_W-1], r_smallest};

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_status <= r_status;
            r_o_count  <= COUNT_OUT_W'(r_count);
            if (r_count < CW'(2)) begin
                r_o_too_few <= 1'b1;
                r_o_short   <= '0;
                r_o_long    <= '0;
            end else begin
                r_o_too_few <= 1'b0;
                r_o_short   <= gap_stat.min_gap;
                r_o_long    <= span[DATA_W-1:0];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_stored_count  = r_o_count;
    assign o_too_few       = r_o_too_few;
    assign o_shortest_span = r_o_short;
    assign o_longest_span  = r_o_long;

    // Assertions.
    `ISST_ASSERT(a_count_bound, r_count <= CW'(MAX_ENTRIES))
    `ISST_ASSERT(a_count_step, r_count == $past(r_count) || r_count == $past(r_count) + CW'(1))
    `ISST_ASSERT_NEXT(a_done_loads, r_state == S_DONE && !r_out_valid, r_out_valid)
    `ISST_ASSERT(a_span_order, !(o_out_valid && !o_too_few) || o_shortest_span <= o_longest_span)
endmodule
`default_nettype wire
